>>> rtl/core/salli_pkg.sv
// shared types and constants for the sorted linked list insert unit
package salli_pkg;

  // width of the value field on the ports
  localparam int unsigned DATA_W = 16;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // status codes
  localparam logic STATUS_DONE     = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    S_INIT    = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_FREE    = 8'b0000_0100,
    S_HEAD    = 8'b0000_1000,
    S_WALK    = 8'b0001_0000,
    S_WR_NODE = 8'b0010_0000,
    S_WR_PREV = 8'b0100_0000,
    S_RD_OUT  = 8'b1000_0000
  } state_t;

endpackage

>>> rtl/core/salli_ram.sv
// generic single write port ram with registered read
module salli_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/sorted_array_linked_list_insert_unit.sv
// top level of the sorted linked list insert unit
//
// keeps an ascending singly linked list of signed values in two memories of
// ENTRIES slots (a value memory and a link memory), with unused slots chained
// on a free list. index ENTRIES stands for null. a transfer is taken when start
// is high and busy is low; exactly one result follows, shown for one cycle with
// done high, and the receiver has no way to hold it off. a read (op 1) gives
// the value and link of one slot, registered out of S_RD_OUT. an insert
// (op 0) pops the first free slot and walks the list from the head, one link
// memory read per node, to the last node whose value is not greater; equal
// values land behind existing ones. behind the head the walk tests one node
// after another, at most ENTRIES - 2 of them (a free slot means the list is
// not full), so the walk over the single read port of the link memory sets
// the rate; an insert in front of the head or into an empty list skips the
// walk, and an overflow (no free slot, nothing changed) answers in the cycle
// after the transfer. after reset, busy stays high while the link memory is
// chained free one slot a cycle. the value of a slot that was never written
// reads back as whatever the memory holds.
module sorted_array_linked_list_insert_unit #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // command side
  input  logic                                start,
  output logic                                busy,
  input  logic                                op,
  input  logic signed [salli_pkg::DATA_W-1:0] value,
  input  logic [$clog2(ENTRIES)-1:0]          slot,
  // result side
  output logic                                done,
  output logic                                status,
  output logic [$clog2(ENTRIES+1)-1:0]        new_slot,
  output logic [$clog2(ENTRIES+1)-1:0]        prev_slot,
  output logic signed [salli_pkg::DATA_W-1:0] read_value,
  output logic [$clog2(ENTRIES+1)-1:0]        read_link
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned IW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] NIL  = IW'(ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  salli_pkg::state_t state;

  // list pointers
  logic [IW-1:0] head_index;
  logic [IW-1:0] free_head;
  logic [IW-1:0] free_next;   // link of the slot being taken off the free list
  logic [IW-1:0] ptr;         // node under test, later the new node's successor
  logic [IW-1:0] save;        // last node not greater, NIL means insert at head
  logic [AW-1:0] init_idx;    // free list chaining pass counter

  // latched command
  logic signed [VALUE_BITS-1:0] item;
  logic [AW-1:0]                slot_r;

  // memory ports
  logic                         v_we;
  logic                         l_we;
  logic [AW-1:0]                waddr;
  logic [AW-1:0]                raddr;
  logic signed [VALUE_BITS-1:0] v_wdata;
  logic [IW-1:0]                l_wdata;
  logic signed [VALUE_BITS-1:0] v_rdata;
  logic [IW-1:0]                l_rdata;

  logic [IW-1:0] l_next;
  logic          item_lt;

  salli_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (waddr),
    .wdata (v_wdata),
    .raddr (raddr),
    .rdata (v_rdata)
  );

  salli_ram #(
    .WIDTH (IW),
    .DEPTH (ENTRIES)
  ) u_link_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (waddr),
    .wdata (l_wdata),
    .raddr (raddr),
    .rdata (l_rdata)
  );

  // any link out of range counts as null
  assign l_next  = (l_rdata >= NIL) ? NIL : l_rdata;
  // new value goes in front of the node just read
  assign item_lt = item < v_rdata;

  assign busy = (state != salli_pkg::S_IDLE);

  // read address: the fsm never reads and writes in the same cycle, so a
  // read always sees the last write to that entry
  always_comb begin
    case (state)
      salli_pkg::S_IDLE: begin
        raddr = (op == salli_pkg::OP_READ) ? slot : free_head[AW-1:0];
      end
      salli_pkg::S_FREE: begin
        raddr = head_index[AW-1:0];
      end
      salli_pkg::S_HEAD, salli_pkg::S_WALK: begin
        raddr = l_next[AW-1:0];
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  // write side
  always_comb begin
    v_we    = 1'b0;
    l_we    = 1'b0;
    waddr   = '0;
    v_wdata = item;
    l_wdata = ptr;
    case (state)
      salli_pkg::S_INIT: begin
        // chain slot i to slot i+1, the last one to null
        l_we    = 1'b1;
        waddr   = init_idx;
        l_wdata = IW'(init_idx) + IW'(1);
      end
      salli_pkg::S_WR_NODE: begin
        v_we  = 1'b1;
        l_we  = 1'b1;
        waddr = free_head[AW-1:0];
      end
      salli_pkg::S_WR_PREV: begin
        l_we    = 1'b1;
        waddr   = save[AW-1:0];
        l_wdata = free_head;
      end
      default: begin
        v_we = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= salli_pkg::S_INIT;
      init_idx   <= '0;
      head_index <= NIL;
      free_head  <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        salli_pkg::S_INIT: begin
          init_idx <= init_idx + AW'(1);
          if (init_idx == LAST) begin
            state <= salli_pkg::S_IDLE;
          end
        end
        salli_pkg::S_IDLE: begin
          if (start) begin
            slot_r <= slot;
            item   <= VALUE_BITS'(value);
            if (op == salli_pkg::OP_READ) begin
              state <= salli_pkg::S_RD_OUT;
            end else if (free_head == NIL) begin
              // no free slot: report and leave the lists alone
              done       <= 1'b1;
              status     <= salli_pkg::STATUS_OVERFLOW;
              new_slot   <= NIL;
              prev_slot  <= NIL;
              read_value <= '0;
              read_link  <= NIL;
            end else begin
              state <= salli_pkg::S_FREE;
            end
          end
        end
        salli_pkg::S_FREE: begin
          free_next <= l_next;
          save      <= NIL;
          if (head_index == NIL) begin
            ptr   <= NIL;
            state <= salli_pkg::S_WR_NODE;
          end else begin
            state <= salli_pkg::S_HEAD;
          end
        end
        salli_pkg::S_HEAD: begin
          if (item_lt) begin
            // new node becomes the head
            ptr   <= head_index;
            state <= salli_pkg::S_WR_NODE;
          end else begin
            save <= head_index;
            ptr  <= l_next;
            state <= (l_next == NIL) ? salli_pkg::S_WR_NODE : salli_pkg::S_WALK;
          end
        end
        salli_pkg::S_WALK: begin
          if (item_lt) begin
            state <= salli_pkg::S_WR_NODE;
          end else begin
            save <= ptr;
            ptr  <= l_next;
            if (l_next == NIL) begin
              state <= salli_pkg::S_WR_NODE;
            end
          end
        end
        salli_pkg::S_WR_NODE: begin
          if (save == NIL) begin
            head_index <= free_head;
            free_head  <= free_next;
            done       <= 1'b1;
            status     <= salli_pkg::STATUS_DONE;
            new_slot   <= free_head;
            prev_slot  <= NIL;
            read_value <= '0;
            read_link  <= NIL;
            state      <= salli_pkg::S_IDLE;
          end else begin
            state <= salli_pkg::S_WR_PREV;
          end
        end
        salli_pkg::S_WR_PREV: begin
          free_head  <= free_next;
          done       <= 1'b1;
          status     <= salli_pkg::STATUS_DONE;
          new_slot   <= free_head;
          prev_slot  <= save;
          read_value <= '0;
          read_link  <= NIL;
          state      <= salli_pkg::S_IDLE;
        end
        salli_pkg::S_RD_OUT: begin
          done      <= 1'b1;
          status    <= salli_pkg::STATUS_DONE;
          new_slot  <= NIL;
          prev_slot <= NIL;
          if (IW'(slot_r) < NIL) begin
            read_value <= salli_pkg::DATA_W'(v_rdata);
            read_link  <= l_next;
          end else begin
            read_value <= '0;
            read_link  <= NIL;
          end
          state <= salli_pkg::S_IDLE;
        end
        default: begin
          state <= salli_pkg::S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // the head of the free list is never the head of the sorted list
  a_free_not_head: assert property (@(posedge clk) disable iff (rst)
    (free_head != NIL) |-> (free_head != head_index))
    else $error("free list head is also list head");

  // the walk only ever tests a real node
  a_walk_ptr_valid: assert property (@(posedge clk) disable iff (rst)
    (state == salli_pkg::S_WALK) |-> (ptr < NIL))
    else $error("walk on a null pointer");

  // overflow is reported only when the free list is empty
  a_overflow_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status == salli_pkg::STATUS_OVERFLOW) |-> (free_head == NIL && new_slot == NIL))
    else $error("overflow with a free slot");

  // an insert behind a node leaves its slot as the free list moves on
  a_insert_pops: assert property (@(posedge clk) disable iff (rst)
    (state == salli_pkg::S_WR_PREV) |=> (free_head != new_slot))
    else $error("inserted slot still heads the free list");
`endif

endmodule
